FILE: rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; every other file of the block refers to this package.
package wsd_pkg;

  // Width of the payload length counter; length bits above it are dropped.
  localparam int LEN_BITS = 64;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] OP_LAST_DATA = 4'd2;
  localparam logic [3:0] OP_CLOSE     = 4'd8;
  localparam logic [3:0] OP_PING      = 4'd9;
  localparam logic [3:0] OP_PONG      = 4'd10;

  localparam logic [7:0] FIN_BIT  = 8'h80;
  localparam logic [7:0] MASK_BIT = 8'h80;

  // Pong header: FIN plus pong opcode, then mask bit with zero length.
  localparam logic [15:0] PONG_REPLY = {FIN_BIT | {4'd0, OP_PONG}, MASK_BIT};

  // Register map (word index).
  localparam logic REG_EXPECT_MASK = 1'b0;

  typedef enum logic [2:0] {
    PH_HDR1   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_MASK   = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RK_NONE  = 2'd0,
    RK_PONG  = 2'd1,
    RK_CLOSE = 2'd2
  } reply_kind_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        frame_end;
    reply_kind_t reply_kind;
    logic [15:0] reply_bytes;
    logic        error;
  } result_t;

endpackage

FILE: rtl/wsd_apb_regs.sv
// APB-style configuration register of the deframer (expect_mask).
// Depends on wsd_pkg for the register map.
module wsd_apb_regs (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready,
  output logic       expect_mask
);

  logic expect_mask_r;
  logic expect_mask_nxt;
  logic sel_mask;

  assign sel_mask   = (cfg_paddr[2] == wsd_pkg::REG_EXPECT_MASK);
  assign cfg_pready = 1'b1;

  always_comb begin
    expect_mask_nxt = expect_mask_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_mask) begin
      expect_mask_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_mask_r <= 1'b0;
    end else begin
      expect_mask_r <= expect_mask_nxt;
    end
  end

  assign cfg_prdata  = sel_mask ? {31'd0, expect_mask_r} : 32'd0;
  assign expect_mask = expect_mask_r;

endmodule

FILE: rtl/wsd_parser.sv
// Frame parse state and the per-word next-state / result logic.
// Depends on wsd_pkg for phases, opcodes and the result struct.
module wsd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic             expect_mask,
  output wsd_pkg::result_t result
);

  localparam int LB = wsd_pkg::LEN_BITS;

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]    hf_r, hf_nxt;
  logic [7:0]    hs_r, hs_nxt;
  logic [LB-1:0] pl_r, pl_nxt;
  logic [3:0]    bl_r, bl_nxt;
  logic [3:0]    bi_r, bi_nxt;
  logic [7:0]    key_r [4];
  logic [7:0]    key_nxt [4];
  logic [1:0]    mp_r, mp_nxt;
  logic          fm_r, fm_nxt;
  logic          err_r, err_nxt;

  logic          len_done;
  logic          do_end;
  logic [63:0]   ext_shift;
  logic [3:0]    op_new;
  logic [3:0]    op_cur;

  assign ext_shift = {56'd0, in_byte} << {bi_r[2:0], 3'b000};
  assign op_new    = in_byte[3:0];
  assign op_cur    = hf_r[3:0];

  always_comb begin
    phase_nxt = phase_r;
    hf_nxt    = hf_r;
    hs_nxt    = hs_r;
    pl_nxt    = pl_r;
    bl_nxt    = bl_r;
    bi_nxt    = bi_r;
    key_nxt   = key_r;
    mp_nxt    = mp_r;
    fm_nxt    = fm_r;
    err_nxt   = err_r;
    len_done  = 1'b0;
    do_end    = 1'b0;
    result    = '0;

    unique case (phase_r)
      wsd_pkg::PH_HDR2: begin
        hs_nxt = in_byte;
        if (expect_mask && !in_byte[7]) begin
          err_nxt = 1'b1;
        end
        if (in_byte[6:0] < wsd_pkg::LEN_CODE_16) begin
          pl_nxt   = {{(LB-7){1'b0}}, in_byte[6:0]};
          len_done = 1'b1;
        end else begin
          pl_nxt    = '0;
          bl_nxt    = (in_byte[6:0] == wsd_pkg::LEN_CODE_16) ? 4'd2 : 4'd8;
          bi_nxt    = 4'd0;
          phase_nxt = wsd_pkg::PH_EXTLEN;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        // Assemble length LSB first; bytes past the counter width fall off.
        pl_nxt = pl_r | ext_shift[LB-1:0];
        bi_nxt = bi_r + 4'd1;
        bl_nxt = bl_r - 4'd1;
        if (bl_nxt == 4'd0) begin
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_MASK: begin
        key_nxt[bi_r[1:0]] = in_byte;
        bi_nxt = bi_r + 4'd1;
        bl_nxt = bl_r - 4'd1;
        if (bl_nxt == 4'd0) begin
          mp_nxt = 2'd0;
          if (pl_r == '0) begin
            do_end = 1'b1;
          end else begin
            phase_nxt = wsd_pkg::PH_BODY;
          end
        end
      end
      wsd_pkg::PH_BODY: begin
        if (op_cur <= wsd_pkg::OP_LAST_DATA) begin
          result.data_valid = 1'b1;
          result.data_byte  = fm_r ? (in_byte ^ key_r[mp_r]) : in_byte;
        end
        if (fm_r) begin
          mp_nxt = mp_r + 2'd1;
        end
        pl_nxt = pl_r - {{(LB-1){1'b0}}, 1'b1};
        if (pl_nxt == '0) begin
          do_end = 1'b1;
        end
      end
      default: begin
        // First header byte; unused phase codes land here too.
        hf_nxt    = in_byte;
        phase_nxt = wsd_pkg::PH_HDR2;
        if (!(op_new <= wsd_pkg::OP_LAST_DATA || op_new == wsd_pkg::OP_CLOSE ||
              op_new == wsd_pkg::OP_PING || op_new == wsd_pkg::OP_PONG)) begin
          err_nxt = 1'b1;
        end
        if (op_new > wsd_pkg::OP_LAST_DATA && !in_byte[7]) begin
          err_nxt = 1'b1;
        end
      end
    endcase

    if (len_done) begin
      fm_nxt = hs_nxt[7];
      if (hs_nxt[7]) begin
        phase_nxt = wsd_pkg::PH_MASK;
        bl_nxt    = 4'd4;
        bi_nxt    = 4'd0;
      end else if (pl_nxt == '0) begin
        do_end = 1'b1;
      end else begin
        phase_nxt = wsd_pkg::PH_BODY;
      end
    end

    if (do_end) begin
      phase_nxt        = wsd_pkg::PH_HDR1;
      result.frame_end = 1'b1;
      if (op_cur == wsd_pkg::OP_CLOSE) begin
        result.reply_kind  = wsd_pkg::RK_CLOSE;
        result.reply_bytes = {hf_r, hs_nxt | wsd_pkg::MASK_BIT};
        err_nxt            = 1'b1;
      end else if (op_cur == wsd_pkg::OP_PING) begin
        result.reply_kind  = wsd_pkg::RK_PONG;
        result.reply_bytes = wsd_pkg::PONG_REPLY;
      end
    end

    result.error = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_HDR1;
      hf_r    <= '0;
      hs_r    <= '0;
      pl_r    <= '0;
      bl_r    <= '0;
      bi_r    <= '0;
      key_r   <= '{default: '0};
      mp_r    <= '0;
      fm_r    <= 1'b0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hf_r    <= hf_nxt;
      hs_r    <= hs_nxt;
      pl_r    <= pl_nxt;
      bl_r    <= bl_nxt;
      bi_r    <= bi_nxt;
      key_r   <= key_nxt;
      mp_r    <= mp_nxt;
      fm_r    <= fm_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

FILE: rtl/wsd_out_reg.sv
// Result register of the deframer: holds one result word until taken.
// Depends on wsd_pkg for the result struct.
module wsd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  input  wsd_pkg::result_t load_data,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_data
);

  logic             valid_r, valid_nxt;
  wsd_pkg::result_t data_r;

  // Slot frees when empty or when the held word is taken this cycle.
  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_apb_regs, wsd_parser and wsd_out_reg.
//
//   channel | direction | handshake             | payload
//   in_     | to block  | in_valid / in_ready   | in_byte
//   out_    | from block| out_valid / out_ready | out_data_valid .. out_error
//   cfg_    | to block  | APB psel/penable      | expect_mask at address 0
//
// One word per cycle sustained while out_ready stays high; a word passes first
// into the input register, then through the parser into the result register.
// The parse state updates in the same edge that loads the result register, so the
// next word sees it at once. Reset (rst_n low, synchronous) empties both
// registers and returns the parser to the first header byte. A stalled
// out_ready holds the result and, one word later, drops in_ready.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic        out_frame_end,
  output logic [1:0]  out_reply_kind,
  output logic [15:0] out_reply_bytes,
  output logic        out_error,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_byte_r;
  logic             expect_mask;
  logic             advance;
  logic             step;
  wsd_pkg::result_t parse_res;
  wsd_pkg::result_t out_res;

  wsd_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .expect_mask (expect_mask)
  );

  // Advance the held word into the parser whenever the result slot frees.
  assign step         = in_valid_r && advance;
  assign in_ready     = !in_valid_r || advance;
  assign in_valid_nxt = in_ready ? in_valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Capture the payload only on an accepted word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .in_byte     (in_byte_r),
    .expect_mask (expect_mask),
    .result      (parse_res)
  );

  wsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid_r),
    .load_data  (parse_res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_res)
  );

  assign out_data_valid  = out_res.data_valid;
  assign out_data_byte   = out_res.data_byte;
  assign out_frame_end   = out_res.frame_end;
  assign out_reply_kind  = out_res.reply_kind;
  assign out_reply_bytes = out_res.reply_bytes;
  assign out_error       = out_res.error;

endmodule

FILE: rtl/wsd_checker.sv
// Port-level checks of the deframer, bound to the top level.
// Depends on wsd_pkg for reply codes.
module wsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_data_valid,
  input logic [7:0]  out_data_byte,
  input logic        out_frame_end,
  input logic [1:0]  out_reply_kind,
  input logic [15:0] out_reply_bytes,
  input logic        out_error
);

  logic err_seen_r, err_seen_nxt;

  assign err_seen_nxt = err_seen_r || (out_valid && out_ready && out_error);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else begin
      err_seen_r <= err_seen_nxt;
    end
  end

  a_reply_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind != wsd_pkg::RK_NONE |-> out_frame_end)
    else $error("reply without frame end");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_data_byte == 8'd0)
    else $error("data byte not zero");

  a_pong_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind == wsd_pkg::RK_PONG |->
      out_reply_bytes == wsd_pkg::PONG_REPLY)
    else $error("bad pong header");

  a_close_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind == wsd_pkg::RK_CLOSE |-> out_error)
    else $error("close without error");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_error)
    else $error("error flag dropped");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_data_valid  (out_data_valid),
  .out_data_byte   (out_data_byte),
  .out_frame_end   (out_frame_end),
  .out_reply_kind  (out_reply_kind),
  .out_reply_bytes (out_reply_bytes),
  .out_error       (out_error)
);

FILE: test/websocket_frame_deframer_test.sv
// Self-checking testbench for websocket_frame_deframer: byte-wide frame stream in,
// one result word per byte out, expect_mask set over the APB-style port.
// Depends on wsd_pkg and the block's RTL; holds its own parse model in a scoreboard class.
module websocket_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run under the worst pacing.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Extra clock edges to let pass at the end, after every owed result is back.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_WORDS = 400;
  localparam logic [2:0] EXPECT_MASK_ADDR = {wsd_pkg::REG_EXPECT_MASK, 2'b00};

  // Directed frames while expect_mask is 0: text with extreme payload, binary
  // non-FIN with a 16-bit length, zero-length continuation ending on its last
  // length byte, masked zero-length ping ending on its last mask byte, and an
  // unmasked zero-length pong ending on byte two.
  localparam logic [7:0] PLAIN_FRAMES [20] = '{
    8'h81, 8'h01, 8'hFF,
    8'h02, 8'h7E, 8'h01, 8'h00, 8'h00,
    8'h80, 8'h7E, 8'h00, 8'h00,
    8'h89, 8'h80, 8'hFF, 8'h00, 8'hA5, 8'h5A,
    8'h8A, 8'h00
  };
  // Directed frames once expect_mask is 1: missing mask, ping without FIN,
  // close with a swallowed payload byte (echo plus sticky error).
  localparam logic [7:0] ERROR_FRAMES [7] = '{
    8'h81, 8'h00,
    8'h09, 8'h00,
    8'h88, 8'h01, 8'h55
  };

  // Parse model of the deframer plus the store of results still owed by the block.
  class deframer_scoreboard;
    logic                         expect_mask;
    wsd_pkg::phase_t              phase;
    logic [7:0]                   hdr_first;
    logic [7:0]                   hdr_second;
    logic [wsd_pkg::LEN_BITS-1:0] payload_left;
    logic [3:0]                   bytes_left;
    logic [3:0]                   byte_index;
    logic [7:0]                   mask_key [4];
    logic [1:0]                   mask_pos;
    logic                         frame_masked;
    logic                         error_flag;
    wsd_pkg::result_t             parsed_results [$];
    int unsigned                  failures;
    int unsigned                  checked;
    int unsigned                  frames_ended;
    int unsigned                  pongs;
    int unsigned                  closes;
    int unsigned                  data_bytes;

    function new();
      expect_mask  = 1'b0;
      phase        = wsd_pkg::PH_HDR1;
      hdr_first    = '0;
      hdr_second   = '0;
      payload_left = '0;
      bytes_left   = '0;
      byte_index   = '0;
      foreach (mask_key[i]) mask_key[i] = '0;
      mask_pos     = '0;
      frame_masked = 1'b0;
      error_flag   = 1'b0;
      failures     = 0;
      checked      = 0;
      frames_ended = 0;
      pongs        = 0;
      closes       = 0;
      data_bytes   = 0;
    endfunction

    function void finish_frame(inout wsd_pkg::result_t r);
      phase       = wsd_pkg::PH_HDR1;
      r.frame_end = 1'b1;
      if (hdr_first[3:0] == wsd_pkg::OP_CLOSE) begin
        r.reply_kind  = wsd_pkg::RK_CLOSE;
        r.reply_bytes = {hdr_first, hdr_second | wsd_pkg::MASK_BIT};
        error_flag    = 1'b1;
      end else if (hdr_first[3:0] == wsd_pkg::OP_PING) begin
        r.reply_kind  = wsd_pkg::RK_PONG;
        r.reply_bytes = wsd_pkg::PONG_REPLY;
      end
    endfunction

    // Length fully known: mask key next, payload next, or the frame is done.
    function void length_known(inout wsd_pkg::result_t r);
      frame_masked = (hdr_second & wsd_pkg::MASK_BIT) != 0;
      if (frame_masked) begin
        phase      = wsd_pkg::PH_MASK;
        bytes_left = 4'd4;
        byte_index = '0;
      end else if (payload_left == 0) begin
        finish_frame(r);
      end else begin
        phase = wsd_pkg::PH_BODY;
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      wsd_pkg::result_t r;
      logic [6:0]       code;
      logic [3:0]       op;
      logic [63:0]      wide;
      int unsigned      sh;
      r = '0;
      case (phase)
        wsd_pkg::PH_HDR2: begin
          code       = b[6:0];
          hdr_second = b;
          if (expect_mask && (b & wsd_pkg::MASK_BIT) == 0) error_flag = 1'b1;
          if (code < wsd_pkg::LEN_CODE_16) begin
            payload_left = wsd_pkg::LEN_BITS'(code);
            length_known(r);
          end else begin
            payload_left = '0;
            bytes_left   = (code == wsd_pkg::LEN_CODE_16) ? 4'd2 : 4'd8;
            byte_index   = '0;
            phase        = wsd_pkg::PH_EXTLEN;
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          // Length bytes arrive least significant first.
          sh = byte_index[2:0] * 8;
          if (sh < wsd_pkg::LEN_BITS) begin
            wide = 64'(b) << sh;
            payload_left = payload_left | wide[wsd_pkg::LEN_BITS-1:0];
          end
          byte_index = byte_index + 4'd1;
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == 0) length_known(r);
        end
        wsd_pkg::PH_MASK: begin
          mask_key[byte_index[1:0]] = b;
          byte_index = byte_index + 4'd1;
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == 0) begin
            mask_pos = '0;
            if (payload_left == 0) finish_frame(r);
            else phase = wsd_pkg::PH_BODY;
          end
        end
        wsd_pkg::PH_BODY: begin
          // Control payload is swallowed; only data opcodes emit bytes.
          if (hdr_first[3:0] <= wsd_pkg::OP_LAST_DATA) begin
            r.data_valid = 1'b1;
            r.data_byte  = frame_masked ? (b ^ mask_key[mask_pos]) : b;
          end
          if (frame_masked) mask_pos = mask_pos + 2'd1;
          payload_left = payload_left - 1'b1;
          if (payload_left == 0) finish_frame(r);
        end
        default: begin
          hdr_first = b;
          phase     = wsd_pkg::PH_HDR2;
          op        = b[3:0];
          if (!(op <= wsd_pkg::OP_LAST_DATA || op == wsd_pkg::OP_CLOSE ||
                op == wsd_pkg::OP_PING || op == wsd_pkg::OP_PONG))
            error_flag = 1'b1;
          if (op > wsd_pkg::OP_LAST_DATA && (b & wsd_pkg::FIN_BIT) == 0) error_flag = 1'b1;
        end
      endcase
      r.error = error_flag;
      parsed_results.push_back(r);
    endfunction

    function void check_result(wsd_pkg::result_t got);
      wsd_pkg::result_t want;
      if (parsed_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected result word %h with nothing outstanding", $time, got);
        return;
      end
      want = parsed_results.pop_front();
      checked++;
      frames_ended += want.frame_end;
      data_bytes   += want.data_valid;
      if (want.reply_kind == wsd_pkg::RK_PONG) pongs++;
      if (want.reply_kind == wsd_pkg::RK_CLOSE) closes++;
      if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
          got.frame_end !== want.frame_end || got.reply_kind !== want.reply_kind ||
          got.reply_bytes !== want.reply_bytes || got.error !== want.error) begin
        failures++;
        if (failures <= 10)
          $display({"[%0t] result %0d mismatch: expected dv=%b db=%h end=%b rk=%0d rb=%h ",
                    "err=%b, got dv=%b db=%h end=%b rk=%0d rb=%h err=%b"}, $time, checked,
                   want.data_valid, want.data_byte, want.frame_end, want.reply_kind,
                   want.reply_bytes, want.error, got.data_valid, got.data_byte,
                   got.frame_end, got.reply_kind, got.reply_bytes, got.error);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_data_valid;
  logic [7:0]  out_data_byte;
  logic        out_frame_end;
  logic [1:0]  out_reply_kind;
  logic [15:0] out_reply_bytes;
  logic        out_error;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  deframer_scoreboard sb = new();
  wsd_pkg::result_t   observed;
  int unsigned        words_sent = 0;
  int unsigned        cycle_count = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;

  websocket_frame_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_valid  (out_data_valid),
    .out_data_byte   (out_data_byte),
    .out_frame_end   (out_frame_end),
    .out_reply_kind  (out_reply_kind),
    .out_reply_bytes (out_reply_bytes),
    .out_error       (out_error),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver pacing: decide each cycle at the falling edge whether to stall.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Take every accepted result word at the rising edge and check it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed.data_valid  = out_data_valid;
      observed.data_byte   = out_data_byte;
      observed.frame_end   = out_frame_end;
      observed.reply_kind  = wsd_pkg::reply_kind_t'(out_reply_kind);
      observed.reply_bytes = out_reply_bytes;
      observed.error       = out_error;
      sb.check_result(observed);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.parsed_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one word: idle at random first, then hold valid and the byte until
  // accepted. Call at a falling edge; returns at the next falling edge.
  task automatic push_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (!in_ready);
    sb.parse_byte(b);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.parsed_results.size() != 0) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_expect_mask(input logic value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = EXPECT_MASK_ADDR;
    cfg_pwdata  = 32'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.expect_mask = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Mostly well-formed frames with random content; now and then a burst of raw
  // noise, after which the stream is steered back to a frame boundary.
  task automatic send_frame();
    int unsigned roll;
    int unsigned len;
    int unsigned ext_bytes;
    logic [3:0]  op;
    logic        fin;
    logic        masked;
    logic [6:0]  code;
    logic [63:0] ext;
    roll = $urandom_range(99);
    if (roll < 8) begin
      // Noise starts at a boundary, so at most one random length byte lands;
      // zero-fill the rest to keep the swallowed payload short.
      repeat ($urandom_range(3, 1)) push_word(8'($urandom));
      while (sb.phase != wsd_pkg::PH_HDR1)
        push_word(sb.phase == wsd_pkg::PH_EXTLEN ? 8'h00 : 8'($urandom));
      return;
    end
    roll = $urandom_range(99);
    if (roll < 70) op = 4'($urandom_range(2));
    else if (roll < 78) op = wsd_pkg::OP_PING;
    else if (roll < 86) op = wsd_pkg::OP_PONG;
    else if (roll < 90) op = wsd_pkg::OP_CLOSE;
    else op = 4'($urandom_range(4) + ($urandom_range(1) ? 3 : 11));
    fin = (op <= wsd_pkg::OP_LAST_DATA) ? 1'($urandom) : ($urandom_range(19) != 0);
    masked = sb.expect_mask ? ($urandom_range(19) != 0) : 1'($urandom);
    roll = $urandom_range(99);
    ext_bytes = 0;
    if (roll < 60) begin
      len = $urandom_range(20);
    end else if (roll < 72) begin
      len = $urandom_range(125, 21);
    end else if (roll < 90) begin
      ext_bytes = 2;
      len = ($urandom_range(9) == 0) ? $urandom_range(300, 256) : $urandom_range(40);
    end else begin
      ext_bytes = 8;
      len = $urandom_range(40);
    end
    if (ext_bytes == 0) code = 7'(len);
    else code = (ext_bytes == 2) ? wsd_pkg::LEN_CODE_16 : wsd_pkg::LEN_CODE_64;
    push_word({fin, 3'($urandom), op});
    push_word({masked, code});
    ext = 64'(len);
    for (int i = 0; i < ext_bytes; i++) push_word(ext[8*i +: 8]);
    if (masked) repeat (4) push_word(8'($urandom));
    repeat (len) push_word(8'($urandom));
  endtask

  // One pacing mode with one expect_mask setting; optionally pause halfway
  // until the block has caught up.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic mask, input bit pause_halfway);
    int unsigned first_word;
    bit          paused;
    wait_drained();
    write_expect_mask(mask);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_word    = words_sent;
    paused        = 1'b0;
    while (words_sent - first_word < PHASE_WORDS) begin
      if (pause_halfway && !paused && words_sent - first_word >= PHASE_WORDS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_frame();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, no idling: clean frames first, since the error flag is sticky.
    write_expect_mask(1'b0);
    foreach (PLAIN_FRAMES[i]) push_word(PLAIN_FRAMES[i]);
    wait_drained();
    write_expect_mask(1'b1);
    foreach (ERROR_FRAMES[i]) push_word(ERROR_FRAMES[i]);

    // Random part: receiver-heavy idling, then sender-heavy, then none.
    run_phase(28, 46, 1'b0, 1'b0);
    run_phase(46, 28, 1'b1, 1'b0);
    run_phase(0, 0, 1'b0, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words: %0d frames ended, %0d payload bytes, %0d pongs,",
             words_sent, sb.frames_ended, sb.data_bytes, sb.pongs);
    $display("%0d closes, with expect_mask 0 and 1 under three pacing modes; %0d checked.",
             sb.closes, sb.checked);
    if (sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failing result words", sb.failures);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
